@@ hw/rtl/ptwpc_pkg.sv @@
`timescale 1ns / 1ps

package ptwpc_pkg;

   // Item kinds on the request channel
   localparam logic REQ_TRANSLATE = 1'b0;
   localparam logic REQ_REPLY     = 1'b1;

   // Result kinds and status codes
   localparam logic RES_READ    = 1'b0;
   localparam logic RES_DONE    = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_FAULT = 1'b1;

   // Descriptor type codes, bits [1:0]
   localparam logic [1:0] DESC_TABLE = 2'b11;
   localparam logic [1:0] DESC_BLOCK = 2'b01;

   // Walk levels
   localparam logic [1:0] LAST_LEVEL = 2'd3;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRANULE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VA_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PA_WIDE = 2'd2;
   localparam int CSR_DATA_W = 6;

   // Reset values of the configuration registers
   localparam logic [4:0] GRANULE_RESET = 5'd12;
   localparam logic [5:0] VA_WIDTH_RESET = 6'd39;

   // Limits for the virtual address width
   localparam logic [5:0] VA_WIDTH_MIN = 6'd25;
   localparam logic [5:0] VA_WIDTH_MAX = 6'd48;

   typedef struct packed {
      logic        req_type;
      logic [21:0] context_id;
      logic [51:0] root_table_addr;
      logic [55:0] virt_addr;
      logic [63:0] descriptor;
      logic        read_fault;
   } req_item_type;

   typedef struct packed {
      logic        res_type;
      logic [51:0] read_addr;
      logic [51:0] phys_addr;
      logic        status;
   } rsp_item_type;

   // Effective configuration seen by the datapath
   typedef struct packed {
      logic [4:0] gran;
      logic [5:0] va_bits;
      logic       wide;
   } cfg_type;

   // Classified item that travels from front to back
   typedef struct packed {
      logic        is_reply;
      logic [21:0] ctx;
      logic [55:0] va;
      logic [1:0]  start_level;
      logic [51:0] read_addr;
      logic [63:0] descriptor;
      logic        read_fault;
   } queue_item_type;

   function automatic logic [4:0] eff_granule(input logic [4:0] gs);
      logic [4:0] g;
      g = 5'd12;
      if (gs == 5'd14) g = 5'd14;
      if (gs == 5'd16) g = 5'd16;
      return g;
   endfunction

   function automatic logic [5:0] eff_va_width(input logic [5:0] vw);
      logic [5:0] v;
      v = vw;
      if (vw < VA_WIDTH_MIN) v = VA_WIDTH_MIN;
      if (vw > VA_WIDTH_MAX) v = VA_WIDTH_MAX;
      return v;
   endfunction

   // Number of walk levels, (v - 4) / (g - 3), by compares against multiples
   function automatic logic [2:0] walk_levels(input logic [4:0] g, input logic [5:0] v);
      logic [5:0] x;
      logic [2:0] q;
      x = v - 6'd4;
      case (g)
         5'd14: begin
            q = 3'({2'b00, x >= 6'd11}) + 3'({2'b00, x >= 6'd22})
              + 3'({2'b00, x >= 6'd33}) + 3'({2'b00, x >= 6'd44});
         end
         5'd16: begin
            q = 3'({2'b00, x >= 6'd13}) + 3'({2'b00, x >= 6'd26})
              + 3'({2'b00, x >= 6'd39});
         end
         default: begin
            q = 3'({2'b00, x >= 6'd9}) + 3'({2'b00, x >= 6'd18})
              + 3'({2'b00, x >= 6'd27}) + 3'({2'b00, x >= 6'd36});
         end
      endcase
      return q;
   endfunction

   // VA shift for the table index at a level: (g - 3) * (4 - lv) + 3
   function automatic logic [5:0] index_shift(input logic [4:0] g, input logic [1:0] lv);
      logic [5:0] gm;
      logic [5:0] s;
      gm = {1'b0, g} - 6'd3;
      case (lv)
         2'd0:    s = gm + gm + gm + gm + 6'd3;
         2'd1:    s = gm + gm + gm + 6'd3;
         2'd2:    s = gm + gm + 6'd3;
         default: s = gm + 6'd3;
      endcase
      return s;
   endfunction

   // Low address bit of a block mapped at a level: (3 - lv) * (g - 3) + g
   function automatic logic [5:0] block_shift(input logic [4:0] g, input logic [1:0] lv);
      logic [5:0] gm;
      logic [5:0] s;
      gm = {1'b0, g} - 6'd3;
      case (lv)
         2'd0:    s = gm + gm + gm + {1'b0, g};
         2'd1:    s = gm + gm + {1'b0, g};
         2'd2:    s = gm + {1'b0, g};
         default: s = {1'b0, g};
      endcase
      return s;
   endfunction

   // Mask of the table index bits, (1 << (g - 3)) - 1
   function automatic logic [12:0] index_mask(input logic [4:0] g);
      logic [4:0] gm;
      gm = g - 5'd3;
      return ~(13'h1FFF << gm);
   endfunction

   function automatic logic [55:0] page_offset_mask(input logic [4:0] g);
      return ~({56{1'b1}} << g);
   endfunction

   // Output address of a descriptor; the wide field lands on bits [51:48]
   function automatic logic [51:0] desc_addr(input logic [63:0] d, input logic [5:0] lowbit,
                                             input logic wide);
      logic [47:0] lo;
      logic [3:0]  hi;
      lo = d[47:0] & ({48{1'b1}} << lowbit);
      hi = wide ? d[15:12] : 4'h0;
      return {hi, lo};
   endfunction

endpackage

@@ hw/rtl/page_table_walker_with_page_cache_top.sv @@
// A transaction passes through the front register, the queue and the result register before it
// raises rsp_valid; replies that find no walk in progress are dropped with no result.
// Throughput: one transaction per cycle while rsp_stall does not hold the result register.
// Reset (synchronous, active high) empties the queue and result register, invalidates the
// page cache, ends any walk, and restores granule 4K, 39-bit VA, 48-bit output format.
`timescale 1ns / 1ps

module page_table_walker_with_page_cache_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel: translate requests and descriptor read replies
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ptwpc_pkg::req_item_type               req_data,
   // Result channel: descriptor read requests and finished translations
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ptwpc_pkg::rsp_item_type               rsp_data,
   // Configuration write port
   input  logic                                  csr_wr_en,
   input  logic [ptwpc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ptwpc_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   // Raw configuration registers, as written
   logic [4:0] granule_ff;
   logic [4:0] granule_in;
   logic [5:0] va_width_ff;
   logic [5:0] va_width_in;
   logic       pa_wide_ff;
   logic       pa_wide_in;
   logic       csr_hit;

   ptwpc_pkg::cfg_type        cfg;

   // Front to queue
   logic                      q_full;
   logic                      q_push;
   ptwpc_pkg::queue_item_type q_item;

   // Queue to back
   logic                      head_valid;
   ptwpc_pkg::queue_item_type head_item;
   logic                      pop;

   // Latch register writes; an index past the list is ignored and flushes nothing
   always_comb begin
      granule_in  = granule_ff;
      va_width_in = va_width_ff;
      pa_wide_in  = pa_wide_ff;
      csr_hit     = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            ptwpc_pkg::CSR_GRANULE: begin
               granule_in = csr_wr_data[4:0];
               csr_hit    = 1'b1;
            end
            ptwpc_pkg::CSR_VA_WIDTH: begin
               va_width_in = csr_wr_data;
               csr_hit     = 1'b1;
            end
            ptwpc_pkg::CSR_PA_WIDE: begin
               pa_wide_in = csr_wr_data[0];
               csr_hit    = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         granule_ff  <= ptwpc_pkg::GRANULE_RESET;
         va_width_ff <= ptwpc_pkg::VA_WIDTH_RESET;
         pa_wide_ff  <= 1'b0;
      end else begin
         granule_ff  <= granule_in;
         va_width_ff <= va_width_in;
         pa_wide_ff  <= pa_wide_in;
      end
   end

   // Granule codes other than 14 and 16 act as 4K; VA width saturates to 25..48
   always_comb begin
      cfg.gran    = ptwpc_pkg::eff_granule(granule_ff);
      cfg.va_bits = ptwpc_pkg::eff_va_width(va_width_ff);
      cfg.wide    = pa_wide_ff;
   end

   // Front: accept, classify, compute the top-level descriptor address
   ptwpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   // Two-entry queue decouples front and back stalls
   ptwpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Back: cache lookup, walk state, result register
   ptwpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .clear      (csr_hit),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

@@ hw/rtl/ptwpc_front.sv @@
`timescale 1ns / 1ps

module ptwpc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  ptwpc_pkg::cfg_type       cfg,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ptwpc_pkg::req_item_type  req_data,
   input  logic                     q_full,
   output logic                     q_push,
   output ptwpc_pkg::queue_item_type q_item
);

   logic                       valid_ff;
   logic                       valid_in;
   ptwpc_pkg::queue_item_type  item_ff;
   ptwpc_pkg::queue_item_type  item_in;
   logic [55:0]                va_clip;
   logic [2:0]                 levels;
   logic [2:0]                 start_wide;
   logic [1:0]                 start_lv;
   logic [5:0]                 sh;
   logic [55:0]                va_shifted;
   logic [12:0]                idx;
   logic                       take;

   assign req_stall = valid_ff && q_full;
   assign take      = req_valid && !req_stall;
   assign q_push    = valid_ff && !q_full;
   assign q_item    = item_ff;

   // Classify and precompute the top-level read address
   always_comb begin
      va_clip    = req_data.virt_addr & ~({56{1'b1}} << cfg.va_bits);
      levels     = ptwpc_pkg::walk_levels(cfg.gran, cfg.va_bits);
      start_wide = 3'd4 - levels;
      start_lv   = start_wide[1:0];
      sh         = ptwpc_pkg::index_shift(cfg.gran, start_lv);
      va_shifted = va_clip >> sh;
      idx        = va_shifted[12:0] & ptwpc_pkg::index_mask(cfg.gran);

      item_in.is_reply    = (req_data.req_type == ptwpc_pkg::REQ_REPLY);
      item_in.ctx         = req_data.context_id;
      item_in.va          = va_clip;
      item_in.start_level = start_lv;
      item_in.read_addr   = req_data.root_table_addr + 52'({idx, 3'b000});
      item_in.descriptor  = req_data.descriptor;
      item_in.read_fault  = req_data.read_fault;
   end

   always_comb begin
      valid_in = valid_ff;
      if (!valid_ff || !q_full) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hw/rtl/ptwpc_queue.sv @@
`timescale 1ns / 1ps

module ptwpc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ptwpc_pkg::queue_item_type push_item,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output ptwpc_pkg::queue_item_type head_item
);

   ptwpc_pkg::queue_item_type entries_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/ptwpc_back.sv @@
`timescale 1ns / 1ps

module ptwpc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ptwpc_pkg::cfg_type        cfg,
   input  logic                      clear,
   input  logic                      head_valid,
   input  ptwpc_pkg::queue_item_type head_item,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ptwpc_pkg::rsp_item_type   rsp_data
);

   // Cache and walk state
   logic        cache_valid_ff;
   logic        cache_valid_in;
   logic [21:0] cached_ctx_ff;
   logic [21:0] cached_ctx_in;
   logic [55:0] cached_va_ff;
   logic [55:0] cached_va_in;
   logic [51:0] cached_pa_ff;
   logic [51:0] cached_pa_in;
   logic        walk_busy_ff;
   logic        walk_busy_in;
   logic [1:0]  walk_level_ff;
   logic [1:0]  walk_level_in;
   logic [55:0] walk_va_ff;
   logic [55:0] walk_va_in;
   logic [21:0] walk_ctx_ff;
   logic [21:0] walk_ctx_in;

   // Result register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   ptwpc_pkg::rsp_item_type  rsp_data_ff;
   ptwpc_pkg::rsp_item_type  rsp_data_in;

   logic                     emit;
   ptwpc_pkg::rsp_item_type  res;
   logic [55:0]              pm;
   logic                     cache_live;
   logic [1:0]               desc_kind;
   logic                     last;
   logic [1:0]               next_lv;
   logic [55:0]              walk_shifted;
   logic [12:0]              next_idx;
   logic [51:0]              page_base;
   logic [5:0]               bb;
   logic [55:0]              blk_off;
   logic [51:0]              page_pa;
   logic [51:0]              blk_pa;
   logic [51:0]              fin_pa;
   logic                     fin_ok;

   assign pop       = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Descriptor decode for the level in progress
   always_comb begin
      pm           = ptwpc_pkg::page_offset_mask(cfg.gran);
      desc_kind    = head_item.descriptor[1:0];
      last         = (walk_level_ff == ptwpc_pkg::LAST_LEVEL);
      next_lv      = walk_level_ff + 2'd1;
      walk_shifted = walk_va_ff >> ptwpc_pkg::index_shift(cfg.gran, next_lv);
      next_idx     = walk_shifted[12:0] & ptwpc_pkg::index_mask(cfg.gran);
      page_base    = ptwpc_pkg::desc_addr(head_item.descriptor, {1'b0, cfg.gran}, cfg.wide);
      bb           = ptwpc_pkg::block_shift(cfg.gran, walk_level_ff);
      blk_off      = walk_va_ff & ~({56{1'b1}} << bb);
      page_pa      = page_base | walk_va_ff[51:0] & pm[51:0];
      blk_pa       = ptwpc_pkg::desc_addr(head_item.descriptor, bb, cfg.wide) | blk_off[51:0];
      cache_live   = cache_valid_ff && (head_item.ctx == cached_ctx_ff);
   end

   always_comb begin
      cache_valid_in = cache_valid_ff;
      cached_ctx_in  = cached_ctx_ff;
      cached_va_in   = cached_va_ff;
      cached_pa_in   = cached_pa_ff;
      walk_busy_in   = walk_busy_ff;
      walk_level_in  = walk_level_ff;
      walk_va_in     = walk_va_ff;
      walk_ctx_in    = walk_ctx_ff;
      emit           = 1'b0;
      fin_ok         = 1'b0;
      fin_pa         = '0;
      res.res_type   = ptwpc_pkg::RES_DONE;
      res.read_addr  = '0;
      res.phys_addr  = '0;
      res.status     = ptwpc_pkg::STATUS_OK;

      if (pop) begin
         if (!head_item.is_reply) begin
            // Translate request: any walk in progress is dropped
            emit         = 1'b1;
            walk_busy_in = 1'b0;
            if (head_item.ctx != cached_ctx_ff) begin
               cache_valid_in = 1'b0;
               cached_ctx_in  = head_item.ctx;
            end
            if (cache_live && cached_va_ff == (head_item.va & ~pm)) begin
               res.phys_addr = cached_pa_ff | head_item.va[51:0] & pm[51:0];
            end else begin
               walk_busy_in  = 1'b1;
               walk_level_in = head_item.start_level;
               walk_va_in    = head_item.va;
               walk_ctx_in   = head_item.ctx;
               res.res_type  = ptwpc_pkg::RES_READ;
               res.read_addr = head_item.read_addr;
            end
         end else if (walk_busy_ff) begin
            // Descriptor reply for the walk in progress
            emit = 1'b1;
            if (head_item.read_fault) begin
               walk_busy_in = 1'b0;
               res.status   = ptwpc_pkg::STATUS_FAULT;
            end else if (desc_kind == ptwpc_pkg::DESC_TABLE && !last) begin
               walk_level_in = next_lv;
               res.res_type  = ptwpc_pkg::RES_READ;
               res.read_addr = page_base | 52'({next_idx, 3'b000});
            end else if (desc_kind == ptwpc_pkg::DESC_TABLE) begin
               fin_ok = 1'b1;
               fin_pa = page_pa;
            end else if (desc_kind == ptwpc_pkg::DESC_BLOCK && !last) begin
               fin_ok = 1'b1;
               fin_pa = blk_pa;
            end else begin
               walk_busy_in = 1'b0;
               res.status   = ptwpc_pkg::STATUS_FAULT;
            end
            if (fin_ok) begin
               walk_busy_in   = 1'b0;
               cache_valid_in = 1'b1;
               cached_ctx_in  = walk_ctx_ff;
               cached_va_in   = walk_va_ff & ~pm;
               cached_pa_in   = fin_pa & ~pm[51:0];
               res.phys_addr  = fin_pa;
            end
         end
      end

      // A write to a configuration register flushes the cache and drops the walk
      if (clear) begin
         cache_valid_in = 1'b0;
         walk_busy_in   = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cache_valid_ff <= 1'b0;
         cached_ctx_ff  <= '0;
         cached_va_ff   <= '0;
         cached_pa_ff   <= '0;
         walk_busy_ff   <= 1'b0;
         walk_level_ff  <= '0;
         walk_va_ff     <= '0;
         walk_ctx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cache_valid_ff <= cache_valid_in;
         cached_ctx_ff  <= cached_ctx_in;
         cached_va_ff   <= cached_va_in;
         cached_pa_ff   <= cached_pa_in;
         walk_busy_ff   <= walk_busy_in;
         walk_level_ff  <= walk_level_in;
         walk_va_ff     <= walk_va_in;
         walk_ctx_ff    <= walk_ctx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
